[sv/sis_pkg.sv]
// shared constants, index tables and result codes for the segment intersection test
// depends on nothing; every other file of the block but sis_hit_if uses it
`default_nettype none

package sis_pkg;

	localparam int COORD_BITS_DEF = 16;

	localparam int NUM_PTS   = 4;
	localparam int NUM_AXES  = 3;
	localparam int NUM_PLANE = 2;
	localparam int NUM_VECS  = 6;
	localparam int NUM_CROSS = 6;
	localparam int NUM_DOTS  = 2;

	// endpoints
	localparam int PT_A = 0;
	localparam int PT_B = 1;
	localparam int PT_C = 2;
	localparam int PT_D = 3;

	// axes
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	// difference vectors, vec = p - q
	localparam int VEC_AB = 0;
	localparam int VEC_AC = 1;
	localparam int VEC_AD = 2;
	localparam int VEC_CD = 3;
	localparam int VEC_CA = 4;
	localparam int VEC_CB = 5;

	localparam int DIFF_P [NUM_VECS] = '{PT_B, PT_C, PT_D, PT_D, PT_A, PT_B};
	localparam int DIFF_Q [NUM_VECS] = '{PT_A, PT_A, PT_A, PT_C, PT_C, PT_C};

	// cross products u x v; dot k uses crosses 2k and 2k+1
	localparam int CR_AC_AB = 0;
	localparam int CR_AD_AB = 1;
	localparam int CR_CA_CD = 2;
	localparam int CR_CB_CD = 3;
	localparam int CR_AB_CD = 4;
	localparam int CR_AB_AC = 5;

	localparam int CROSS_U [NUM_CROSS] = '{VEC_AC, VEC_AD, VEC_CA, VEC_CB, VEC_AB, VEC_AB};
	localparam int CROSS_V [NUM_CROSS] = '{VEC_AB, VEC_AB, VEC_CD, VEC_CD, VEC_CD, VEC_AC};

	// side values
	localparam int DOT_CD = 0;
	localparam int DOT_AB = 1;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_CROSS     = 2'd1,
		KIND_TOUCH     = 2'd2,
		KIND_COLLINEAR = 2'd3
	} hit_kind_t;

endpackage

`default_nettype wire

[sv/sis_pair_if.sv]
// valid/ready channel carrying one segment pair (twelve coordinates)
// depends on sis_pkg for the default coordinate width
`default_nettype none

interface sis_pair_if #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
	logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
	logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
	logic signed [COORD_BITS-1:0] d_x, d_y, d_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
		output ready
	);
endinterface

`default_nettype wire

[sv/sis_hit_if.sv]
// valid/ready channel carrying one intersection verdict
// no dependencies
`default_nettype none

interface sis_hit_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic [1:0] hit_kind;

	modport source (output valid, hit, hit_kind, input ready);
	modport sink (input valid, hit, hit_kind, output ready);
endinterface

`default_nettype wire

[sv/sis_diff.sv]
// stage 1: endpoint difference vectors and x/y copies for the ordering test
// depends on sis_pkg
`default_nettype none

module sis_diff #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] pt     [sis_pkg::NUM_PTS][sis_pkg::NUM_AXES],
	output logic signed [COORD_BITS:0]   vec_s1 [sis_pkg::NUM_VECS][sis_pkg::NUM_AXES],
	output logic signed [COORD_BITS-1:0] pxy_s1 [sis_pkg::NUM_PTS][sis_pkg::NUM_PLANE]
);
	import sis_pkg::*;

	localparam int MSB = COORD_BITS - 1;

	for (genvar v = 0; v < NUM_VECS; v++) begin : g_vec
		for (genvar a = 0; a < NUM_AXES; a++) begin : g_ax
			always_ff @(posedge clk) begin
				if (en) begin
					vec_s1[v][a] <= {pt[DIFF_P[v]][a][MSB], pt[DIFF_P[v]][a]}
						- {pt[DIFF_Q[v]][a][MSB], pt[DIFF_Q[v]][a]};
				end
			end
		end
	end

	for (genvar p = 0; p < NUM_PTS; p++) begin : g_pt
		for (genvar a = 0; a < NUM_PLANE; a++) begin : g_ax
			always_ff @(posedge clk) begin
				if (en) begin
					pxy_s1[p][a] <= pt[p][a];
				end
			end
		end
	end

endmodule

`default_nettype wire

[sv/sis_cross.sv]
// stage 2: six cross products of difference vectors and the collinear containment order test
// depends on sis_pkg
`default_nettype none

module sis_cross #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [COORD_BITS:0]       vec_s1 [sis_pkg::NUM_VECS][sis_pkg::NUM_AXES],
	input  logic signed [COORD_BITS-1:0]     pxy_s1 [sis_pkg::NUM_PTS][sis_pkg::NUM_PLANE],
	output logic signed [2*COORD_BITS+2:0]   cr_s2  [sis_pkg::NUM_CROSS][sis_pkg::NUM_AXES],
	output logic                             inside_s2
);
	import sis_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	// strict order by x, then y
	function automatic logic precedes(
		input logic signed [COORD_BITS-1:0] px,
		input logic signed [COORD_BITS-1:0] py,
		input logic signed [COORD_BITS-1:0] qx,
		input logic signed [COORD_BITS-1:0] qy
	);
		return (px != qx) ? (px < qx) : (py < qy);
	endfunction

	for (genvar k = 0; k < NUM_CROSS; k++) begin : g_cr
		for (genvar j = 0; j < NUM_AXES; j++) begin : g_cmp
			logic signed [PW-1:0] p_pos;
			logic signed [PW-1:0] p_neg;

			assign p_pos = vec_s1[CROSS_U[k]][(j+1)%NUM_AXES] * vec_s1[CROSS_V[k]][(j+2)%NUM_AXES];
			assign p_neg = vec_s1[CROSS_U[k]][(j+2)%NUM_AXES] * vec_s1[CROSS_V[k]][(j+1)%NUM_AXES];

			always_ff @(posedge clk) begin
				if (en) begin
					cr_s2[k][j] <= {p_pos[PW-1], p_pos} - {p_neg[PW-1], p_neg};
				end
			end
		end
	end

	// endpoints of each segment put in order, then strict containment of cd in ab
	logic                         ab_ord, cd_ord, inside_d;
	logic signed [COORD_BITS-1:0] lo1 [NUM_PLANE];
	logic signed [COORD_BITS-1:0] hi1 [NUM_PLANE];
	logic signed [COORD_BITS-1:0] lo2 [NUM_PLANE];
	logic signed [COORD_BITS-1:0] hi2 [NUM_PLANE];

	always_comb begin
		ab_ord = precedes(pxy_s1[PT_A][AX_X], pxy_s1[PT_A][AX_Y],
			pxy_s1[PT_B][AX_X], pxy_s1[PT_B][AX_Y]);
		cd_ord = precedes(pxy_s1[PT_C][AX_X], pxy_s1[PT_C][AX_Y],
			pxy_s1[PT_D][AX_X], pxy_s1[PT_D][AX_Y]);
		for (int a = 0; a < NUM_PLANE; a++) begin
			lo1[a] = ab_ord ? pxy_s1[PT_A][a] : pxy_s1[PT_B][a];
			hi1[a] = ab_ord ? pxy_s1[PT_B][a] : pxy_s1[PT_A][a];
			lo2[a] = cd_ord ? pxy_s1[PT_C][a] : pxy_s1[PT_D][a];
			hi2[a] = cd_ord ? pxy_s1[PT_D][a] : pxy_s1[PT_C][a];
		end
		inside_d = precedes(lo1[AX_X], lo1[AX_Y], lo2[AX_X], lo2[AX_Y])
			&& precedes(hi2[AX_X], hi2[AX_Y], hi1[AX_X], hi1[AX_Y]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s2 <= inside_d;
		end
	end

endmodule

`default_nettype wire

[sv/sis_dot.sv]
// stages 3 and 4: split multiplies of cross components into exact full products,
// plus the zero-vector test for the collinear case; depends on sis_pkg
`default_nettype none

module sis_dot #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en_s3,
	input  logic                           en_s4,
	input  logic signed [2*COORD_BITS+2:0] cr_s2   [sis_pkg::NUM_CROSS][sis_pkg::NUM_AXES],
	input  logic                           inside_s2,
	output logic signed [4*COORD_BITS+5:0] prod_s4 [sis_pkg::NUM_DOTS][sis_pkg::NUM_AXES],
	output logic                           col_s4,
	output logic                           inside_s4
);
	import sis_pkg::*;

	localparam int CW = 2 * COORD_BITS + 3;
	localparam int LW = (CW + 1) / 2;
	localparam int HW = CW - LW;
	localparam int PW = 2 * CW;

	for (genvar m = 0; m < NUM_DOTS; m++) begin : g_dot
		for (genvar j = 0; j < NUM_AXES; j++) begin : g_term
			logic signed [HW-1:0]    uh, vh;
			logic signed [LW:0]      ul, vl;
			logic signed [2*HW-1:0]  hh_s3;
			logic signed [HW+LW:0]   hl_s3, lh_s3;
			logic signed [2*LW+1:0]  ll_s3;
			logic signed [PW-1:0]    hh_x, hl_x, lh_x, ll_x;

			// high half signed, low half as a non-negative value
			assign uh = cr_s2[2*m][j][CW-1:LW];
			assign vh = cr_s2[2*m+1][j][CW-1:LW];
			assign ul = {1'b0, cr_s2[2*m][j][LW-1:0]};
			assign vl = {1'b0, cr_s2[2*m+1][j][LW-1:0]};

			always_ff @(posedge clk) begin
				if (en_s3) begin
					hh_s3 <= uh * vh;
					hl_s3 <= uh * vl;
					lh_s3 <= ul * vh;
					ll_s3 <= ul * vl;
				end
			end

			assign hh_x = {{(PW-2*HW){hh_s3[2*HW-1]}}, hh_s3};
			assign hl_x = {{(PW-HW-LW-1){hl_s3[HW+LW]}}, hl_s3};
			assign lh_x = {{(PW-HW-LW-1){lh_s3[HW+LW]}}, lh_s3};
			assign ll_x = {{(PW-2*LW-2){ll_s3[2*LW+1]}}, ll_s3};

			always_ff @(posedge clk) begin
				if (en_s4) begin
					prod_s4[m][j] <= (hh_x << (2*LW)) + ((hl_x + lh_x) << LW) + ll_x;
				end
			end
		end
	end

	logic col_s3, inside_s3;
	logic col_d;

	always_comb begin
		col_d = 1'b1;
		for (int j = 0; j < NUM_AXES; j++) begin
			if (cr_s2[CR_AB_CD][j] != '0 || cr_s2[CR_AB_AC][j] != '0) begin
				col_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			col_s3    <= col_d;
			inside_s3 <= inside_s2;
		end
		if (en_s4) begin
			col_s4    <= col_s3;
			inside_s4 <= inside_s3;
		end
	end

endmodule

`default_nettype wire

[sv/sis_classify.sv]
// stage 5: sums the dot products, takes their signs and registers the verdict
// depends on sis_pkg
`default_nettype none

module sis_classify #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [4*COORD_BITS+5:0] prod_s4 [sis_pkg::NUM_DOTS][sis_pkg::NUM_AXES],
	input  logic                           col_s4,
	input  logic                           inside_s4,
	output logic                           hit_s5,
	output sis_pkg::hit_kind_t             kind_s5
);
	import sis_pkg::*;

	localparam int PW   = 4 * COORD_BITS + 6;
	localparam int DOTW = PW + 2;

	logic [DOTW-1:0]     sum  [NUM_DOTS];
	logic [NUM_DOTS-1:0] neg, zero;
	hit_kind_t           kind_d;

	always_comb begin
		for (int m = 0; m < NUM_DOTS; m++) begin
			sum[m] = {{2{prod_s4[m][AX_X][PW-1]}}, prod_s4[m][AX_X]}
				+ {{2{prod_s4[m][AX_Y][PW-1]}}, prod_s4[m][AX_Y]}
				+ {{2{prod_s4[m][AX_Z][PW-1]}}, prod_s4[m][AX_Z]};
			neg[m]  = sum[m][DOTW-1];
			zero[m] = (sum[m] == '0);
		end

		if (neg[DOT_AB] && neg[DOT_CD]) begin
			kind_d = KIND_CROSS;
		end else if ((neg[DOT_AB] && zero[DOT_CD]) || (neg[DOT_CD] && zero[DOT_AB])) begin
			kind_d = KIND_TOUCH;
		end else if (col_s4 && inside_s4) begin
			kind_d = KIND_COLLINEAR;
		end else begin
			kind_d = KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5 <= kind_d;
			hit_s5  <= (kind_d != KIND_NONE);
		end
	end

endmodule

`default_nettype wire

[sv/segment_intersection_test_top.sv]
// segment intersection test: top level, valid chain and stall control
// depends on sis_pkg, sis_pair_if, sis_hit_if, sis_diff, sis_cross, sis_dot, sis_classify
//
// usage
//   pair   : sink channel; one word holds segments ab and cd as twelve signed
//            coordinates of COORD_BITS bits each
//   result : source channel; one word per pair: hit, and hit_kind
//            (none, proper crossing, endpoint touch, collinear containment)
//   a word is taken at a rising edge with valid and ready both high
//   an accepted pair passes through s1 to s5; result.valid rises once it is in s5
//   one pair per cycle while the output is not stalled; five pairs can be in flight, one per stage
//   the five stages of the pipeline are:
//     s1 differences, s2 cross products, s3 split partial products,
//     s4 full products, s5 dot sums, signs and verdict (the output register)
//   stalls: each stage holds while the stage after it is full and stalled, so
//   empty stages keep filling; pair.ready drops only when every stage is full
//   and result.ready is low; nothing is dropped or repeated
//   reset: arst_n clears all stage valid bits at once; the block is ready to
//   take a word as soon as reset is released
`default_nettype none

module segment_intersection_test_top #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	sis_pair_if.sink         pair,
	sis_hit_if.source        result
);
	import sis_pkg::*;

	localparam int CW = 2 * COORD_BITS + 3;
	localparam int PW = 2 * CW;

	// stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// a stage loads when it is empty or its content moves on
	assign en_s5 = !v_s5 || result.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign pair.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pair.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// endpoints gathered into one array
	logic signed [COORD_BITS-1:0] pt [NUM_PTS][NUM_AXES];

	always_comb begin
		pt[PT_A][AX_X] = pair.a_x;
		pt[PT_A][AX_Y] = pair.a_y;
		pt[PT_A][AX_Z] = pair.a_z;
		pt[PT_B][AX_X] = pair.b_x;
		pt[PT_B][AX_Y] = pair.b_y;
		pt[PT_B][AX_Z] = pair.b_z;
		pt[PT_C][AX_X] = pair.c_x;
		pt[PT_C][AX_Y] = pair.c_y;
		pt[PT_C][AX_Z] = pair.c_z;
		pt[PT_D][AX_X] = pair.d_x;
		pt[PT_D][AX_Y] = pair.d_y;
		pt[PT_D][AX_Z] = pair.d_z;
	end

	logic signed [COORD_BITS:0]   vec_s1  [NUM_VECS][NUM_AXES];
	logic signed [COORD_BITS-1:0] pxy_s1  [NUM_PTS][NUM_PLANE];
	logic signed [CW-1:0]         cr_s2   [NUM_CROSS][NUM_AXES];
	logic                         inside_s2;
	logic signed [PW-1:0]         prod_s4 [NUM_DOTS][NUM_AXES];
	logic                         col_s4, inside_s4;
	logic                         hit_s5;
	hit_kind_t                    kind_s5;

	// s1: difference vectors
	sis_diff #(.COORD_BITS(COORD_BITS)) u_diff (
		.clk    (clk),
		.en     (en_s1),
		.pt     (pt),
		.vec_s1 (vec_s1),
		.pxy_s1 (pxy_s1)
	);

	// s2: cross products and endpoint ordering
	sis_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk       (clk),
		.en        (en_s2),
		.vec_s1    (vec_s1),
		.pxy_s1    (pxy_s1),
		.cr_s2     (cr_s2),
		.inside_s2 (inside_s2)
	);

	// s3, s4: dot product terms built from half-width multiplies
	sis_dot #(.COORD_BITS(COORD_BITS)) u_dot (
		.clk       (clk),
		.en_s3     (en_s3),
		.en_s4     (en_s4),
		.cr_s2     (cr_s2),
		.inside_s2 (inside_s2),
		.prod_s4   (prod_s4),
		.col_s4    (col_s4),
		.inside_s4 (inside_s4)
	);

	// s5: side signs and verdict, doubles as the output register
	sis_classify #(.COORD_BITS(COORD_BITS)) u_classify (
		.clk       (clk),
		.en        (en_s5),
		.prod_s4   (prod_s4),
		.col_s4    (col_s4),
		.inside_s4 (inside_s4),
		.hit_s5    (hit_s5),
		.kind_s5   (kind_s5)
	);

	assign result.valid    = v_s5;
	assign result.hit      = hit_s5;
	assign result.hit_kind = kind_s5;

	// hit flag agrees with the case code
	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.hit == (result.hit_kind != KIND_NONE)))
		else $error("hit flag disagrees with hit_kind");

	// an empty first stage always takes a word
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> pair.ready)
		else $error("input stalled with stage 1 empty");

	// an accepted word reaches stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pair.valid && pair.ready) |=> v_s1)
		else $error("accepted word lost at stage 1");

	// a word leaving stage 4 lands in the output stage
	a_s4_to_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s5) |=> v_s5)
		else $error("word lost between stage 4 and 5");

	// a stalled result is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !result.ready) |=> (v_s5 && $stable(kind_s5)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
